@@ hdl/wsd_pkg.sv @@
// Shared types and constants of the WebSocket frame deframer.
// Used by wsd_parser, wsd_out_skid and websocket_frame_deframer.
package wsd_pkg;

   typedef enum logic [2:0] {
      PH_HDR0 = 3'd0,
      PH_HDR1 = 3'd1,
      PH_EXT  = 3'd2,
      PH_MASK = 3'd3,
      PH_DATA = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_RESERVED = 2'd0,
      ERR_OPCODE   = 2'd1,
      ERR_TOO_LONG = 2'd2
   } err_type;

   localparam logic [3:0] OP_CONT   = 4'h0;
   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;
   localparam logic [3:0] OP_PONG   = 4'hA;

   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;

   localparam logic [2:0] EXT16_COUNT = 3'd1;
   localparam logic [2:0] EXT64_COUNT = 3'd7;

   localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd16777216;

   typedef struct packed {
      kind_type    kind;
      logic        fin;
      logic [3:0]  opcode;
      logic        masked;
      logic [31:0] payload_length;
      logic [7:0]  data;
      logic        last;
      err_type     error_code;
   } rsp_type;

endpackage

@@ hdl/wsd_parser.sv @@
// Header state machine and payload unmasking of the WebSocket frame deframer.
// Depends on wsd_pkg.
module wsd_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [7:0]       in_byte,
   input  logic [31:0]      max_payload,
   output logic             res_valid,
   output wsd_pkg::rsp_type res
);
   import wsd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [2:0]  ext_count_ff, ext_count_in;
   logic [31:0] len_lo_ff, len_lo_in;
   logic        len_hi_ff, len_hi_in;
   logic [31:0] mask_key_ff, mask_key_in;
   logic [31:0] remaining_ff, remaining_in;
   logic [1:0]  mask_pos_ff, mask_pos_in;
   logic        hdr_fin_ff, hdr_fin_in;
   logic [3:0]  hdr_opcode_ff, hdr_opcode_in;
   logic        hdr_masked_ff, hdr_masked_in;

   logic        lk_fire;
   logic        lk_hi;
   logic [31:0] lk_lo;
   logic        opcode_ok;
   logic [7:0]  key_byte;
   logic [31:0] remaining_dec;

   always_comb begin
      case (in_byte[3:0]) inside
         OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG: opcode_ok = 1'b1;
         default: opcode_ok = 1'b0;
      endcase
   end

   assign key_byte      = mask_key_ff[{~mask_pos_ff, 3'b000} +: 8];
   assign remaining_dec = remaining_ff - 32'd1;

   always_comb begin
      phase_in      = phase_ff;
      ext_count_in  = ext_count_ff;
      len_lo_in     = len_lo_ff;
      len_hi_in     = len_hi_ff;
      mask_key_in   = mask_key_ff;
      remaining_in  = remaining_ff;
      mask_pos_in   = mask_pos_ff;
      hdr_fin_in    = hdr_fin_ff;
      hdr_opcode_in = hdr_opcode_ff;
      hdr_masked_in = hdr_masked_ff;
      lk_fire       = 1'b0;
      lk_hi         = 1'b0;
      lk_lo         = 32'd0;
      res_valid     = 1'b0;
      res           = '0;

      unique case (phase_ff)
         PH_HDR1: begin
            hdr_masked_in = in_byte[7];
            len_lo_in     = 32'd0;
            len_hi_in     = 1'b0;
            if (in_byte[6:0] == LEN7_EXT16) begin
               ext_count_in = EXT16_COUNT;
               phase_in     = PH_EXT;
            end else if (in_byte[6:0] == LEN7_EXT64) begin
               ext_count_in = EXT64_COUNT;
               phase_in     = PH_EXT;
            end else begin
               lk_fire = 1'b1;
               lk_lo   = {25'd0, in_byte[6:0]};
            end
         end
         PH_EXT: begin
            len_lo_in = {len_lo_ff[23:0], in_byte};
            len_hi_in = len_hi_ff | (len_lo_ff[31:24] != 8'd0);
            if (ext_count_ff == 3'd0) begin
               lk_fire = 1'b1;
               lk_hi   = len_hi_in;
               lk_lo   = len_lo_in;
            end else begin
               ext_count_in = ext_count_ff - 3'd1;
            end
         end
         PH_MASK: begin
            mask_key_in = {mask_key_ff[23:0], in_byte};
            if (mask_pos_ff == 2'd3) begin
               mask_pos_in        = 2'd0;
               phase_in           = (remaining_ff == 32'd0) ? PH_HDR0 : PH_DATA;
               res_valid          = 1'b1;
               res.kind           = KIND_HEADER;
               res.fin            = hdr_fin_ff;
               res.opcode         = hdr_opcode_ff;
               res.masked         = hdr_masked_ff;
               res.payload_length = remaining_ff;
               res.last           = (remaining_ff == 32'd0);
            end else begin
               mask_pos_in = mask_pos_ff + 2'd1;
            end
         end
         PH_DATA: begin
            remaining_in = remaining_dec;
            mask_pos_in  = mask_pos_ff + 2'd1;
            if (remaining_dec == 32'd0) begin
               phase_in = PH_HDR0;
            end
            res_valid  = 1'b1;
            res.kind   = KIND_PAYLOAD;
            res.fin    = hdr_fin_ff;
            res.opcode = hdr_opcode_ff;
            res.masked = hdr_masked_ff;
            res.data   = in_byte ^ key_byte;
            res.last   = (remaining_dec == 32'd0);
         end
         default: begin
            phase_in = PH_HDR0;
            if (in_byte[6:4] != 3'd0) begin
               res_valid      = 1'b1;
               res.kind       = KIND_ERROR;
               res.error_code = ERR_RESERVED;
            end else if (!opcode_ok) begin
               res_valid      = 1'b1;
               res.kind       = KIND_ERROR;
               res.error_code = ERR_OPCODE;
            end else begin
               hdr_fin_in    = in_byte[7];
               hdr_opcode_in = in_byte[3:0];
               phase_in      = PH_HDR1;
            end
         end
      endcase

      if (lk_fire) begin
         if (lk_hi || (lk_lo > max_payload)) begin
            phase_in       = PH_HDR0;
            res_valid      = 1'b1;
            res            = '0;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_TOO_LONG;
         end else begin
            remaining_in = lk_lo;
            mask_key_in  = 32'd0;
            mask_pos_in  = 2'd0;
            if (hdr_masked_in) begin
               phase_in = PH_MASK;
            end else begin
               phase_in           = (lk_lo == 32'd0) ? PH_HDR0 : PH_DATA;
               res_valid          = 1'b1;
               res.kind           = KIND_HEADER;
               res.fin            = hdr_fin_ff;
               res.opcode         = hdr_opcode_ff;
               res.masked         = hdr_masked_in;
               res.payload_length = lk_lo;
               res.last           = (lk_lo == 32'd0);
            end
         end
      end

      if (!in_valid) begin
         res_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR0;
      end else if (in_valid) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         ext_count_ff  <= ext_count_in;
         len_lo_ff     <= len_lo_in;
         len_hi_ff     <= len_hi_in;
         mask_key_ff   <= mask_key_in;
         remaining_ff  <= remaining_in;
         mask_pos_ff   <= mask_pos_in;
         hdr_fin_ff    <= hdr_fin_in;
         hdr_opcode_ff <= hdr_opcode_in;
         hdr_masked_ff <= hdr_masked_in;
      end
   end

   a_data_gives_result: assert property (@(posedge clock) disable iff (reset)
      in_valid && (phase_ff == PH_DATA) |-> res_valid && (res.kind == KIND_PAYLOAD))
      else $error("payload transaction produced no payload result");

   a_empty_header_last: assert property (@(posedge clock) disable iff (reset)
      res_valid && (res.kind == KIND_HEADER) |-> res.last == (res.payload_length == 32'd0))
      else $error("header last flag disagrees with payload length");

   a_hdr0_advances: assert property (@(posedge clock) disable iff (reset)
      in_valid && (phase_ff == PH_HDR0) && !res_valid |=> phase_ff == PH_HDR1)
      else $error("valid first header byte did not advance to second byte");

   a_length_in_limit: assert property (@(posedge clock) disable iff (reset)
      res_valid && (res.kind == KIND_HEADER) |-> res.payload_length <= max_payload)
      else $error("header reported a length above the limit");

endmodule

@@ hdl/wsd_out_skid.sv @@
// Output register with skid stage for the deframer result channel.
// Depends on wsd_pkg.
module wsd_out_skid (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  wsd_pkg::rsp_type in_res,
   output logic             in_ready,
   output logic             out_valid,
   output wsd_pkg::rsp_type out_res,
   input  logic             out_ready
);
   import wsd_pkg::*;

   logic    main_valid_ff;
   logic    skid_valid_ff;
   rsp_type main_ff;
   rsp_type skid_ff;
   logic    main_free;

   assign main_free = !main_valid_ff || out_ready;
   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_res   = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (main_free) begin
         if (skid_valid_ff) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= in_valid;
         end else begin
            main_valid_ff <= in_valid;
         end
      end else if (in_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (main_free) begin
         if (skid_valid_ff) begin
            main_ff <= skid_ff;
            if (in_valid) begin
               skid_ff <= in_res;
            end
         end else if (in_valid) begin
            main_ff <= in_res;
         end
      end else if (in_valid) begin
         skid_ff <= in_res;
      end
   end

   a_skid_implies_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid stage holds a result ahead of the output register");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> !skid_valid_ff)
      else $error("result written while both stages are full");

   a_held_output: assert property (@(posedge clock) disable iff (reset)
      main_valid_ff && !out_ready |=> main_valid_ff && $stable(main_ff))
      else $error("stalled result changed");

endmodule

@@ hdl/websocket_frame_deframer.sv @@
// WebSocket receive deframer: one received byte per transaction in, one header,
// payload or error result out. Uses wsd_pkg, wsd_parser and wsd_out_skid.
//
// Each byte is taken, and any result it completes is registered at the same
// edge; bytes may enter back to back at one per clock while req_tready is high.
// The output side has an output register and a skid stage, so req_tready depends
// only on registered state and drops only when two results wait. Header bytes,
// extended length and mask key produce no result until the header is complete;
// errors return the parser to expecting a new first header byte. The user must
// write max_payload via csr_we/csr_wdata only while idle; this is not enforced.
module websocket_frame_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // [0] fin, [4:1] opcode, [5] masked,
                                   // [37:6] payload_length, [45:38] data,
                                   // [47:46] error_code
   output logic [1:0]  rsp_tuser,  // [1:0] kind
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);
   import wsd_pkg::*;

   logic [31:0] max_payload_ff;
   logic        req_accept;
   logic        res_valid;
   rsp_type     res;
   rsp_type     out_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else if (csr_we) begin
         max_payload_ff <= csr_wdata;
      end
   end

   assign req_accept = req_tvalid && req_tready;

   wsd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_accept),
      .in_byte     (req_tdata),
      .max_payload (max_payload_ff),
      .res_valid   (res_valid),
      .res         (res)
   );

   wsd_out_skid u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_res    (res),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_res   (out_res),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {out_res.error_code, out_res.data, out_res.payload_length,
                       out_res.masked, out_res.opcode, out_res.fin};
   assign rsp_tuser = out_res.kind;
   assign rsp_tlast = out_res.last;

endmodule
